>>> rtl/mhpq_pkg.sv
`timescale 1ns / 1ps

package mhpq_pkg;

  // Number of cells, one key per cell
  localparam int unsigned CAPACITY = 64;
  // Entry counter width, wide enough to hold CAPACITY itself
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Field widths fixed by the interface
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OUT_W    = ((KEY_W + COUNT_W + 7) / 8) * 8;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Command broadcast to every cell in the row
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic signed [KEY_W-1:0] key;
  } cmd_t;

  // What a cell shows its neighbors
  typedef struct packed {
    logic                    valid;
    logic                    keep;  // holds a key >= the incoming key
    logic signed [KEY_W-1:0] val;
  } link_t;

endpackage

>>> rtl/mhpq_cell.sv
`timescale 1ns / 1ps

// One slot of the sorted row. Keys run from largest (cell 0) to smallest.
// Insert: cells holding a key >= the new key stay, the first cell below
// them takes the new key and the rest take their left neighbor's key.
// Delete: every cell takes its right neighbor's key.
module mhpq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mhpq_pkg::cmd_t    cmd_i,
  input  mhpq_pkg::link_t   left_i,
  input  mhpq_pkg::link_t   right_i,
  output mhpq_pkg::link_t   link_o
);

  logic                              valid_q, valid_d;
  logic signed [mhpq_pkg::KEY_W-1:0] val_q, val_d;
  logic                              keep;

  // Compare against the incoming key
  assign keep = valid_q && (val_q >= cmd_i.key);

  // Next slot contents
  always_comb begin
    valid_d = valid_q;
    val_d   = val_q;
    if (cmd_i.ins) begin
      valid_d = valid_q | left_i.valid;
      if (!keep) begin
        val_d = left_i.keep ? cmd_i.key : left_i.val;
      end
    end else if (cmd_i.del) begin
      valid_d = right_i.valid;
      val_d   = right_i.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Key storage, meaningful only while valid
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.keep  = keep;
  assign link_o.val   = val_q;

endmodule

>>> rtl/max_heap_priority_queue_core.sv
`timescale 1ns / 1ps

// Channel  Dir  tdata (low bit up)                          tuser
// s_axis   in   value[31:0]                                  opcode
// m_axis   out  removed_value[31:0], count_after[38:32], 0   status[1:0]
//
// Each request is done at once: the whole row of cells shifts or
// inserts together, so a new request is taken every cycle unless the output stalls.
// The result sits in an output register; a request is taken while it is
// empty or being read, so a stalled output holds the input off.
// Reset clears the cell valid bits and the count; no clearing pass.
module max_heap_priority_queue_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [mhpq_pkg::KEY_W-1:0]     s_axis_tdata,  // value
  input  logic                           s_axis_tuser,  // opcode
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [mhpq_pkg::OUT_W-1:0]     m_axis_tdata,  // removed_value, count_after, pad
  output logic [mhpq_pkg::STATUS_W-1:0]  m_axis_tuser   // status
);

  localparam int unsigned N = mhpq_pkg::CAPACITY;

  mhpq_pkg::cmd_t                    cmd;
  mhpq_pkg::link_t                   links [N];
  mhpq_pkg::link_t                   left_in [N];
  mhpq_pkg::link_t                   right_in [N];
  logic [N-1:0]                      valid_vec;

  logic [mhpq_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic                              m_valid_q;
  logic signed [mhpq_pkg::KEY_W-1:0] removed_q;
  mhpq_pkg::status_e                 status_q, status_d;
  logic [mhpq_pkg::COUNT_W-1:0]      count_q;

  logic                              accept, full, empty, do_ins, do_del;
  mhpq_pkg::op_e                     op;

  // Request decode
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op            = mhpq_pkg::op_e'(s_axis_tuser);
  assign full          = (cnt_q == mhpq_pkg::CNT_W'(N));
  assign empty         = (cnt_q == '0);
  assign do_ins        = accept && (op == mhpq_pkg::OP_INSERT) && !full;
  assign do_del        = accept && (op == mhpq_pkg::OP_DELETE) && !empty;

  assign cmd.ins = do_ins;
  assign cmd.del = do_del;
  assign cmd.key = $signed(s_axis_tdata);

  // Row of cells with neighbor links; the ends are tied off
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_in[i] = '{valid: 1'b1, keep: 1'b1, val: '0};
    end else begin : g_mid_l
      assign left_in[i] = links[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_in[i] = '{valid: 1'b0, keep: 1'b0, val: '0};
    end else begin : g_mid_r
      assign right_in[i] = links[i+1];
    end

    mhpq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (left_in[i]),
      .right_i (right_in[i]),
      .link_o  (links[i])
    );

    assign valid_vec[i] = links[i].valid;
  end

  // Count and status
  always_comb begin
    cnt_d    = cnt_q;
    status_d = mhpq_pkg::ST_OK;
    if (do_ins) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_del) begin
      cnt_d = cnt_q - 1'b1;
    end
    if (op == mhpq_pkg::OP_INSERT && full) begin
      status_d = mhpq_pkg::ST_FULL;
    end else if (op == mhpq_pkg::OP_DELETE && empty) begin
      status_d = mhpq_pkg::ST_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q <= cnt_d;
      end
      if (accept) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_q <= do_del ? links[0].val : '0;
      status_q  <= status_d;
      count_q   <= mhpq_pkg::COUNT_W'(cnt_d);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = mhpq_pkg::OUT_W'({count_q, removed_q});
  assign m_axis_tuser  = status_q;

`ifndef ASSERT_OFF
  // Count never passes capacity
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mhpq_pkg::CNT_W'(N))
    else $error("entry count above capacity");

  // Occupied cells match the count
  a_cnt_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(cnt_q))
    else $error("cell valid bits disagree with count");

  // Head cell holds a key no smaller than the next cell's
  a_head_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_vec[1] |-> (links[0].val >= links[1].val))
    else $error("head cell is not the maximum");

  // A good delete returns the former head key
  a_del_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_del |=> (m_axis_tvalid && removed_q == $past(links[0].val)))
    else $error("delete did not return head key");
`endif

endmodule
